>>> rtl/stable_merge_sort_engine_macros.svh
// Assertion macros for the stable merge sort engine
`ifndef STABLE_MERGE_SORT_ENGINE_MACROS_SVH
`define STABLE_MERGE_SORT_ENGINE_MACROS_SVH

// same-cycle implication
`define SMSE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SMSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/smse_pkg.sv
// Shared constants, types and compare function of the merge sort engine
package smse_pkg;

   localparam int DEPTH     = 64;
   localparam int KEY_WIDTH = 32;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int PTR_W     = $clog2(DEPTH) + 2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SEG_CHECK,
      ST_PAIR_START,
      ST_PRE_R,
      ST_DEC1,
      ST_PRE_L,
      ST_DEC2,
      ST_MERGE,
      ST_SWAP_LEFT,
      ST_PAIR_NEXT,
      ST_FETCH_A,
      ST_FETCH_B,
      ST_FETCH_C,
      ST_CPY_RD,
      ST_CPY_WR,
      ST_EM_A,
      ST_EM_B,
      ST_EM_C,
      ST_EM_D
   } state_type;

   typedef enum logic [1:0] {
      SLOT_X,
      SLOT_L,
      SLOT_R
   } slot_type;

   typedef enum logic [1:0] {
      WSEL_LOAD,
      WSEL_L,
      WSEL_R,
      WSEL_RD
   } wsel_type;

   typedef struct packed {
      logic              cur;
      logic [IDX_W-1:0]  idx_raddr;
      logic              idx_we;
      logic              idx_wr_src;
      logic [IDX_W-1:0]  idx_waddr;
      wsel_type          idx_wsel;
      logic              key_we;
      logic [IDX_W-1:0]  key_waddr;
      logic              lat_idx;
      logic              lat_key;
      slot_type          slot;
      logic              out_idx_ld;
      logic              out_key_ld;
   } cmd_type;

   typedef struct packed {
      logic x_lt_r;
      logic x_lt_l;
      logic r_lt_l;
   } sts_type;

   function automatic logic key_less(input logic [KEY_WIDTH-1:0] x,
                                     input logic [KEY_WIDTH-1:0] y,
                                     input logic                 sgn);
      logic [KEY_WIDTH-1:0] xa;
      logic [KEY_WIDTH-1:0] ya;
      xa = x;
      ya = y;
      if (sgn) begin
         xa[KEY_WIDTH-1] = ~x[KEY_WIDTH-1];
         ya[KEY_WIDTH-1] = ~y[KEY_WIDTH-1];
      end
      return xa < ya;
   endfunction

endpackage

>>> rtl/smse_ram.sv
// Generic single-write, single-read RAM with registered read data
module smse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/smse_ctrl.sv
// Sequencer for load, merge passes and emission
module smse_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_reordered,
   output logic               rsp_overflow,
   output logic               rsp_last_out,
   output smse_pkg::cmd_type  cmd,
   input  smse_pkg::sts_type  sts
);

   localparam int PW = smse_pkg::PTR_W;
   localparam int IW = smse_pkg::IDX_W;

   smse_pkg::state_type state_ff, state_in;
   smse_pkg::state_type ret_ff, ret_in;
   smse_pkg::state_type cret_ff, cret_in;
   smse_pkg::slot_type  fslot_ff, fslot_in;
   logic [PW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] seg_ff, seg_in;
   logic [PW-1:0] i_ff, i_in;
   logic [PW-1:0] a_ff, a_in;
   logic [PW-1:0] e1_ff, e1_in;
   logic [PW-1:0] b_ff, b_in;
   logic [PW-1:0] e2_ff, e2_in;
   logic [PW-1:0] k_ff, k_in;
   logic [PW-1:0] cp_ff, cp_in;
   logic [PW-1:0] cend_ff, cend_in;
   logic [PW-1:0] fpos_ff, fpos_in;
   logic [PW-1:0] r_ff, r_in;
   logic cur_ff, cur_in;
   logic reorder_ff, reorder_in;
   logic overflow_ff, overflow_in;
   logic valid_ff, valid_in;
   logic last_ff, last_in;

   logic [PW-1:0] i_seg;
   logic [PW-1:0] pe1;
   logic [PW-1:0] e1_seg;
   logic [PW-1:0] pe2;

   assign i_seg  = i_ff + seg_ff;
   assign pe1    = (i_seg < cnt_ff) ? i_seg : cnt_ff;
   assign e1_seg = pe1 + seg_ff;
   assign pe2    = (e1_seg < cnt_ff) ? e1_seg : cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= smse_pkg::ST_IDLE;
         cnt_ff      <= '0;
         cur_ff      <= 1'b0;
         reorder_ff  <= 1'b0;
         overflow_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         cur_ff      <= cur_in;
         reorder_ff  <= reorder_in;
         overflow_ff <= overflow_in;
         valid_ff    <= valid_in;
      end
      ret_ff   <= ret_in;
      cret_ff  <= cret_in;
      fslot_ff <= fslot_in;
      seg_ff   <= seg_in;
      i_ff     <= i_in;
      a_ff     <= a_in;
      e1_ff    <= e1_in;
      b_ff     <= b_in;
      e2_ff    <= e2_in;
      k_ff     <= k_in;
      cp_ff    <= cp_in;
      cend_ff  <= cend_in;
      fpos_ff  <= fpos_in;
      r_ff     <= r_in;
      last_ff  <= last_in;
   end

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      cret_in     = cret_ff;
      fslot_in    = fslot_ff;
      cnt_in      = cnt_ff;
      seg_in      = seg_ff;
      i_in        = i_ff;
      a_in        = a_ff;
      e1_in       = e1_ff;
      b_in        = b_ff;
      e2_in       = e2_ff;
      k_in        = k_ff;
      cp_in       = cp_ff;
      cend_in     = cend_ff;
      fpos_in     = fpos_ff;
      r_in        = r_ff;
      cur_in      = cur_ff;
      reorder_in  = reorder_ff;
      overflow_in = overflow_ff;
      valid_in    = valid_ff;
      last_in     = last_ff;

      cmd            = '0;
      cmd.cur        = cur_ff;
      cmd.key_waddr  = cnt_ff[IW-1:0];
      cmd.idx_waddr  = k_ff[IW-1:0];
      cmd.idx_wsel   = smse_pkg::WSEL_RD;
      cmd.slot       = fslot_ff;
      req_ready      = 1'b0;

      case (state_ff)
         smse_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (cnt_ff < PW'(smse_pkg::DEPTH)) begin
                  cmd.key_we     = 1'b1;
                  cmd.idx_we     = 1'b1;
                  cmd.idx_wr_src = 1'b1;
                  cmd.idx_waddr  = cnt_ff[IW-1:0];
                  cmd.idx_wsel   = smse_pkg::WSEL_LOAD;
                  cnt_in         = cnt_ff + 1'b1;
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_last) begin
                  seg_in   = PW'(1);
                  state_in = smse_pkg::ST_SEG_CHECK;
               end
            end
         end
         smse_pkg::ST_SEG_CHECK: begin
            i_in = '0;
            r_in = '0;
            if (seg_ff >= cnt_ff) begin
               state_in = smse_pkg::ST_EM_A;
            end else begin
               state_in = smse_pkg::ST_PAIR_START;
            end
         end
         smse_pkg::ST_PAIR_START: begin
            a_in  = i_ff;
            e1_in = pe1;
            b_in  = pe1;
            e2_in = pe2;
            k_in  = i_ff;
            if (pe2 <= pe1) begin
               cp_in    = i_ff;
               cend_in  = pe1;
               cret_in  = smse_pkg::ST_PAIR_NEXT;
               state_in = smse_pkg::ST_CPY_RD;
            end else begin
               fpos_in  = pe1 - 1'b1;
               fslot_in = smse_pkg::SLOT_X;
               ret_in   = smse_pkg::ST_PRE_R;
               state_in = smse_pkg::ST_FETCH_A;
            end
         end
         smse_pkg::ST_PRE_R: begin
            fpos_in  = b_ff;
            fslot_in = smse_pkg::SLOT_R;
            ret_in   = smse_pkg::ST_DEC1;
            state_in = smse_pkg::ST_FETCH_A;
         end
         smse_pkg::ST_DEC1: begin
            if (sts.x_lt_r) begin
               cp_in    = a_ff;
               cend_in  = e2_ff;
               cret_in  = smse_pkg::ST_PAIR_NEXT;
               state_in = smse_pkg::ST_CPY_RD;
            end else begin
               fpos_in  = e2_ff - 1'b1;
               fslot_in = smse_pkg::SLOT_X;
               ret_in   = smse_pkg::ST_PRE_L;
               state_in = smse_pkg::ST_FETCH_A;
            end
         end
         smse_pkg::ST_PRE_L: begin
            fpos_in  = a_ff;
            fslot_in = smse_pkg::SLOT_L;
            ret_in   = smse_pkg::ST_DEC2;
            state_in = smse_pkg::ST_FETCH_A;
         end
         smse_pkg::ST_DEC2: begin
            if (sts.x_lt_l) begin
               reorder_in = 1'b1;
               cp_in      = b_ff;
               cend_in    = e2_ff;
               cret_in    = smse_pkg::ST_SWAP_LEFT;
               state_in   = smse_pkg::ST_CPY_RD;
            end else begin
               state_in = smse_pkg::ST_MERGE;
            end
         end
         smse_pkg::ST_MERGE: begin
            cmd.idx_we = 1'b1;
            k_in       = k_ff + 1'b1;
            if (sts.r_lt_l) begin
               cmd.idx_wsel = smse_pkg::WSEL_R;
               reorder_in   = 1'b1;
               b_in         = b_ff + 1'b1;
               if (b_ff + 1'b1 < e2_ff) begin
                  fpos_in  = b_ff + 1'b1;
                  fslot_in = smse_pkg::SLOT_R;
                  ret_in   = smse_pkg::ST_MERGE;
                  state_in = smse_pkg::ST_FETCH_A;
               end else begin
                  cp_in    = a_ff;
                  cend_in  = e1_ff;
                  cret_in  = smse_pkg::ST_PAIR_NEXT;
                  state_in = smse_pkg::ST_CPY_RD;
               end
            end else begin
               cmd.idx_wsel = smse_pkg::WSEL_L;
               a_in         = a_ff + 1'b1;
               if (a_ff + 1'b1 < e1_ff) begin
                  fpos_in  = a_ff + 1'b1;
                  fslot_in = smse_pkg::SLOT_L;
                  ret_in   = smse_pkg::ST_MERGE;
                  state_in = smse_pkg::ST_FETCH_A;
               end else begin
                  cp_in    = b_ff;
                  cend_in  = e2_ff;
                  cret_in  = smse_pkg::ST_PAIR_NEXT;
                  state_in = smse_pkg::ST_CPY_RD;
               end
            end
         end
         smse_pkg::ST_SWAP_LEFT: begin
            cp_in    = a_ff;
            cend_in  = e1_ff;
            cret_in  = smse_pkg::ST_PAIR_NEXT;
            state_in = smse_pkg::ST_CPY_RD;
         end
         smse_pkg::ST_PAIR_NEXT: begin
            if (i_seg + seg_ff >= cnt_ff) begin
               cur_in   = ~cur_ff;
               seg_in   = seg_ff + seg_ff;
               state_in = smse_pkg::ST_SEG_CHECK;
            end else begin
               i_in     = i_seg + seg_ff;
               state_in = smse_pkg::ST_PAIR_START;
            end
         end
         smse_pkg::ST_FETCH_A: begin
            cmd.idx_raddr = fpos_ff[IW-1:0];
            state_in      = smse_pkg::ST_FETCH_B;
         end
         smse_pkg::ST_FETCH_B: begin
            cmd.lat_idx = 1'b1;
            state_in    = smse_pkg::ST_FETCH_C;
         end
         smse_pkg::ST_FETCH_C: begin
            cmd.lat_key = 1'b1;
            state_in    = ret_ff;
         end
         smse_pkg::ST_CPY_RD: begin
            cmd.idx_raddr = cp_ff[IW-1:0];
            if (cp_ff >= cend_ff) begin
               state_in = cret_ff;
            end else begin
               state_in = smse_pkg::ST_CPY_WR;
            end
         end
         smse_pkg::ST_CPY_WR: begin
            cmd.idx_we = 1'b1;
            cp_in      = cp_ff + 1'b1;
            k_in       = k_ff + 1'b1;
            state_in   = smse_pkg::ST_CPY_RD;
         end
         smse_pkg::ST_EM_A: begin
            cmd.idx_raddr = r_ff[IW-1:0];
            state_in      = smse_pkg::ST_EM_B;
         end
         smse_pkg::ST_EM_B: begin
            cmd.out_idx_ld = 1'b1;
            state_in       = smse_pkg::ST_EM_C;
         end
         smse_pkg::ST_EM_C: begin
            cmd.out_key_ld = 1'b1;
            valid_in       = 1'b1;
            last_in        = (r_ff + 1'b1 == cnt_ff);
            state_in       = smse_pkg::ST_EM_D;
         end
         smse_pkg::ST_EM_D: begin
            if (rsp_ready) begin
               valid_in = 1'b0;
               if (last_ff) begin
                  cnt_in      = '0;
                  cur_in      = 1'b0;
                  reorder_in  = 1'b0;
                  overflow_in = 1'b0;
                  state_in    = smse_pkg::ST_IDLE;
               end else begin
                  r_in     = r_ff + 1'b1;
                  state_in = smse_pkg::ST_EM_A;
               end
            end
         end
         default: begin
            state_in = smse_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid     = valid_ff;
   assign rsp_reordered = reorder_ff;
   assign rsp_overflow  = overflow_ff;
   assign rsp_last_out  = last_ff;

endmodule

>>> rtl/smse_dp.sv
// Key store, ping-pong index stores, head registers and comparators
module smse_dp (
   input  logic                            clock,
   input  logic                            csr_write_enable,
   input  logic                            csr_write_data,
   input  logic [31:0]                     req_key,
   input  smse_pkg::cmd_type               cmd,
   output smse_pkg::sts_type               sts,
   output logic [31:0]                     rsp_sorted_key,
   output logic [5:0]                      rsp_original_index
);

   localparam int KW = smse_pkg::KEY_WIDTH;
   localparam int IW = smse_pkg::IDX_W;

   logic          signed_ff;
   logic [KW-1:0] x_key_ff;
   logic [KW-1:0] l_key_ff;
   logic [KW-1:0] r_key_ff;
   logic [IW-1:0] l_idx_ff;
   logic [IW-1:0] r_idx_ff;
   logic [KW-1:0] out_key_ff;
   logic [IW-1:0] out_idx_ff;

   logic [KW-1:0] key_rdata;
   logic [IW-1:0] rd_a;
   logic [IW-1:0] rd_b;
   logic [IW-1:0] src_rdata;
   logic [IW-1:0] wdata;
   logic          tgt_a;

   assign src_rdata = cmd.cur ? rd_b : rd_a;
   assign tgt_a     = (cmd.cur == 1'b0) == cmd.idx_wr_src;

   always_comb begin
      case (cmd.idx_wsel)
         smse_pkg::WSEL_LOAD: wdata = cmd.idx_waddr;
         smse_pkg::WSEL_L:    wdata = l_idx_ff;
         smse_pkg::WSEL_R:    wdata = r_idx_ff;
         default:             wdata = src_rdata;
      endcase
   end

   smse_ram #(.WIDTH(KW), .DEPTH(smse_pkg::DEPTH)) u_key_ram (
      .clock (clock),
      .we    (cmd.key_we),
      .waddr (cmd.key_waddr),
      .wdata (KW'(req_key)),
      .raddr (src_rdata),
      .rdata (key_rdata)
   );

   smse_ram #(.WIDTH(IW), .DEPTH(smse_pkg::DEPTH)) u_idx_a (
      .clock (clock),
      .we    (cmd.idx_we && tgt_a),
      .waddr (cmd.idx_waddr),
      .wdata (wdata),
      .raddr (cmd.idx_raddr),
      .rdata (rd_a)
   );

   smse_ram #(.WIDTH(IW), .DEPTH(smse_pkg::DEPTH)) u_idx_b (
      .clock (clock),
      .we    (cmd.idx_we && !tgt_a),
      .waddr (cmd.idx_waddr),
      .wdata (wdata),
      .raddr (cmd.idx_raddr),
      .rdata (rd_b)
   );

   always_ff @(posedge clock) begin
      if (csr_write_enable) begin
         signed_ff <= csr_write_data;
      end
      if (cmd.lat_idx) begin
         if (cmd.slot == smse_pkg::SLOT_L) begin
            l_idx_ff <= src_rdata;
         end
         if (cmd.slot == smse_pkg::SLOT_R) begin
            r_idx_ff <= src_rdata;
         end
      end
      if (cmd.lat_key) begin
         case (cmd.slot)
            smse_pkg::SLOT_X: x_key_ff <= key_rdata;
            smse_pkg::SLOT_L: l_key_ff <= key_rdata;
            smse_pkg::SLOT_R: r_key_ff <= key_rdata;
            default: ;
         endcase
      end
      if (cmd.out_idx_ld) begin
         out_idx_ff <= src_rdata;
      end
      if (cmd.out_key_ld) begin
         out_key_ff <= key_rdata;
      end
   end

   assign sts.x_lt_r = smse_pkg::key_less(x_key_ff, r_key_ff, signed_ff);
   assign sts.x_lt_l = smse_pkg::key_less(x_key_ff, l_key_ff, signed_ff);
   assign sts.r_lt_l = smse_pkg::key_less(r_key_ff, l_key_ff, signed_ff);

   assign rsp_sorted_key     = 32'(out_key_ff);
   assign rsp_original_index = 6'(out_idx_ff);

endmodule

>>> rtl/stable_merge_sort_engine.sv
// Top level of the stable merge sort engine
// Usage:
//  Keys arrive on the req_ channel, one per beat; the beat with req_last high
//  closes the set. Keys beyond the store depth are dropped and flagged.
//  req_ready is high only while loading; one key loads per cycle.
//  After the closing beat the block runs bottom-up merge passes over an index
//  permutation held in two ping-pong RAMs, then emits one rsp_ beat per key in
//  ascending order with its load position, the reordered and overflow flags,
//  and rsp_last_out on the final beat.
//  Each head fetch reads the index RAM, then the key RAM. Result beats go out
//  one at a time; a new one is fetched only after the receiver takes the current.
//  A stalled rsp_ beat holds until taken.
//  csr_write_data selects signed compare; write it only while idle.
//  Reset (synchronous, active high) empties the set and clears the flags;
//  the compare mode resets to unsigned.
`include "stable_merge_sort_engine_macros.svh"
module stable_merge_sort_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_key,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_sorted_key,
   output logic [5:0]  rsp_original_index,
   output logic        rsp_reordered,
   output logic        rsp_overflow,
   output logic        rsp_last_out
);

   smse_pkg::cmd_type cmd;
   smse_pkg::sts_type sts;
   logic              csr_we;

   assign csr_we = csr_write_enable || reset;

   smse_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_reordered (rsp_reordered),
      .rsp_overflow  (rsp_overflow),
      .rsp_last_out  (rsp_last_out),
      .cmd           (cmd),
      .sts           (sts)
   );

   smse_dp u_dp (
      .clock              (clock),
      .csr_write_enable   (csr_we),
      .csr_write_data     (csr_write_data && !reset),
      .req_key            (req_key),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_sorted_key     (rsp_sorted_key),
      .rsp_original_index (rsp_original_index)
   );

   `SMSE_ASSERT_SAME(a_no_load_while_emit, clock, reset, req_ready, !rsp_valid, "load during emit")
   `SMSE_ASSERT_SAME(a_merge_write_busy, clock, reset, cmd.idx_we && !cmd.idx_wr_src, !req_ready, "merge write while idle")
   `SMSE_ASSERT_NEXT(a_idle_after_last, clock, reset, rsp_valid && rsp_ready && rsp_last_out, req_ready, "not idle after set")

endmodule

>>> bench/stable_merge_sort_engine_tb.sv
// Self-checking testbench for the stable merge sort engine
`timescale 1ns / 1ps
module stable_merge_sort_engine_tb;

   typedef struct {
      logic [31:0] key;
      logic        last;
   } key_beat_type;

   typedef struct {
      logic [31:0] sorted_key;
      logic [5:0]  original_index;
      logic        reordered;
      logic        overflow;
      logic        last_out;
   } rank_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic        csr_write_data;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_key = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_sorted_key;
   logic [5:0]  rsp_original_index;
   logic        rsp_reordered;
   logic        rsp_overflow;
   logic        rsp_last_out;

   stable_merge_sort_engine uut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_key(req_key),
      .req_last(req_last), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_sorted_key(rsp_sorted_key), .rsp_original_index(rsp_original_index),
      .rsp_reordered(rsp_reordered), .rsp_overflow(rsp_overflow),
      .rsp_last_out(rsp_last_out)
   );

   key_beat_type pending_keys[$];
   rank_type     expected_ranks[$];
   logic [31:0]  set_keys[smse_pkg::DEPTH];
   int           set_count = 0;
   logic         set_overflow = 1'b0;
   logic         signed_mode;
   int           mismatches = 0;
   int           send_idle_pct;
   int           recv_stall_pct;
   int           hold_off = 0;
   logic         hold_fired = 1'b0;
   logic         hold_arm;
   int           cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic precedes(logic [31:0] x, logic [31:0] y);
      if (signed_mode)
         return $signed(x) < $signed(y);
      return x < y;
   endfunction

   // bottom-up stable merge with whole-run copy shortcuts
   task automatic sort_and_expect();
      logic [5:0] perm[smse_pkg::DEPTH];
      logic [5:0] scratch[smse_pkg::DEPTH];
      logic       moved;
      int         seg, i, a, b, e1, e2, k, r;
      moved = 1'b0;
      for (r = 0; r < set_count; r++)
         perm[r] = r[5:0];
      for (seg = 1; seg < set_count; seg += seg) begin
         for (i = 0; i < set_count; i += 2 * seg) begin
            a = i;
            e1 = (a + seg < set_count) ? a + seg : set_count;
            b = e1;
            e2 = (b + seg < set_count) ? b + seg : set_count;
            k = a;
            if (e2 > b && precedes(set_keys[perm[e1-1]], set_keys[perm[b]])) begin
               while (a < e2) scratch[k++] = perm[a++];
            end else if (e2 > b && precedes(set_keys[perm[e2-1]], set_keys[perm[a]])) begin
               while (b < e2) scratch[k++] = perm[b++];
               while (a < e1) scratch[k++] = perm[a++];
               moved = 1'b1;
            end else begin
               while (a < e1 && b < e2) begin
                  if (precedes(set_keys[perm[b]], set_keys[perm[a]])) begin
                     scratch[k++] = perm[b++];
                     moved = 1'b1;
                  end else begin
                     scratch[k++] = perm[a++];
                  end
               end
               while (a < e1) scratch[k++] = perm[a++];
               while (b < e2) scratch[k++] = perm[b++];
            end
         end
         for (r = 0; r < set_count; r++)
            perm[r] = scratch[r];
      end
      for (r = 0; r < set_count; r++)
         expected_ranks.push_back('{set_keys[perm[r]], perm[r], moved, set_overflow,
                                    r == set_count - 1});
      set_count = 0;
      set_overflow = 1'b0;
   endtask

   task automatic absorb_key(input key_beat_type kb);
      if (set_count < smse_pkg::DEPTH)
         set_keys[set_count++] = kb.key;
      else
         set_overflow = 1'b1;
      if (kb.last)
         sort_and_expect();
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            absorb_key(pending_keys.pop_front());
         end
         if (!(req_valid && !req_ready)) begin
            if (pending_keys.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_key   <= pending_keys[0].key;
               req_last  <= pending_keys[0].last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, started once by the first result beat after arming
   always @(posedge clock) begin
      if (reset) begin
         hold_off   <= 0;
         hold_fired <= 1'b0;
      end else if (hold_arm && !hold_fired && rsp_valid) begin
         hold_off   <= 300;
         hold_fired <= 1'b1;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_ranks.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected beat: key %h idx %0d", rsp_sorted_key,
                           rsp_original_index);
            end else begin
               rank_type e;
               e = expected_ranks.pop_front();
               if (e.sorted_key !== rsp_sorted_key || e.original_index !== rsp_original_index
                   || e.reordered !== rsp_reordered || e.overflow !== rsp_overflow
                   || e.last_out !== rsp_last_out) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %h/%0d/%b/%b/%b got %h/%0d/%b/%b/%b",
                              e.sorted_key, e.original_index, e.reordered, e.overflow,
                              e.last_out, rsp_sorted_key, rsp_original_index,
                              rsp_reordered, rsp_overflow, rsp_last_out);
               end
            end
         end
         if (hold_off > 0) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 1500000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] pick_key(int style);
      case (style)
         0: return $urandom_range(7);
         1: return 32'hFFFF_FFF8 | $urandom_range(7);
         2: return 32'h7FFF_FFFC + $urandom_range(7);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_set(int n, int style);
      int i;
      for (i = 0; i < n; i++)
         pending_keys.push_back('{pick_key(style), i == n - 1});
   endtask

   task automatic wait_drained();
      while (pending_keys.size() > 0 || req_valid || expected_ranks.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_mode(logic v);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      signed_mode = v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   int sent, n, phase;

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      signed_mode = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_arm = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single key, extremes, sorted, reversed, ties
      pending_keys.push_back('{32'h0, 1'b1});
      pending_keys.push_back('{32'hFFFF_FFFF, 1'b0});
      pending_keys.push_back('{32'h8000_0000, 1'b0});
      pending_keys.push_back('{32'h7FFF_FFFF, 1'b0});
      pending_keys.push_back('{32'h0, 1'b1});
      for (int i = 0; i < 4; i++) pending_keys.push_back('{i, i == 3});
      for (int i = 0; i < 4; i++) pending_keys.push_back('{10 - i, i == 3});
      for (int i = 0; i < 5; i++) pending_keys.push_back('{5, i == 4});
      wait_drained();
      write_mode(1'b1);
      pending_keys.push_back('{32'hFFFF_FFFF, 1'b0});
      pending_keys.push_back('{32'h8000_0000, 1'b0});
      pending_keys.push_back('{32'h7FFF_FFFF, 1'b0});
      pending_keys.push_back('{32'h1, 1'b1});
      wait_drained();

      // full store plus dropped keys, then a long receiver hold-off during
      // emission while the next set is already offered
      hold_arm = 1'b1;
      for (int i = 0; i < smse_pkg::DEPTH + 3; i++)
         pending_keys.push_back('{$urandom, i == smse_pkg::DEPTH + 2});
      queue_set(8, 3);
      wait_drained();

      sent = 0;
      for (phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         write_mode(phase[0] ^ phase[2]);
         while (sent < 45 * (phase + 1)) begin
            n = ($urandom_range(15) == 0) ? $urandom_range(64) + 1 : $urandom_range(12) + 1;
            queue_set(n, $urandom_range(3));
            sent += n;
         end
         wait_drained();
      end
      write_mode(1'b0);

      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
